// File: rtl/assert_macros.svh
// Assertion macros, used by the controller in rtl/prt_ctl.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// A condition that, once seen, forces another at the same edge.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// File: rtl/prt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peer registration table package
// Shared constants, command and result codes, and the structs that pass
// between the controller and the row of slot cells.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam logic [15:0] SEQ_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_REG     = 2'd0,
        CMD_UNREG   = 2'd1,
        CMD_LIST    = 2'd2,
        CMD_UNKNOWN = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_SEQ   = 3'd0,
        KIND_OK    = 3'd1,
        KIND_NOK   = 3'd2,
        KIND_ENTRY = 3'd3,
        KIND_END   = 3'd4
    } t_kind;

    // Per-cycle control for the cell row.
    typedef struct packed {
        logic shift;   // move the token one cell along
        logic act;     // let the cell holding the token do its work
    } t_step;

    // Command held for the whole walk, seen by every cell.
    typedef struct packed {
        t_cmd        op;
        logic [31:0] addr;
        logic [15:0] port;
        logic [15:0] seq_arg;
        logic [15:0] issue_seq;
    } t_bcast;

    // What a cell shows to its neighbour and to the controller.
    typedef struct packed {
        logic        tok;
        logic        done;
        logic        valid;
        logic [15:0] seq;
        logic [31:0] addr;
        logic [15:0] port;
    } t_cell;

endpackage

// File: rtl/prt_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request and response channels
// Valid/ready channels carrying one command item and one result item.
// ----------------------------------------------------------------------------
interface prt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [15:0] seq_arg;

    modport source (output valid, cmd, peer_addr, peer_port, seq_arg, input ready);
    modport sink   (input valid, cmd, peer_addr, peer_port, seq_arg, output ready);
endinterface

interface prt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] seq_out;
    logic [31:0] addr_out;
    logic [15:0] port_out;
    logic        last;

    modport source (output valid, kind, seq_out, addr_out, port_out, last, input ready);
    modport sink   (input valid, kind, seq_out, addr_out, port_out, last, output ready);
endinterface

// File: rtl/prt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peer registration table slot cell
// Holds one slot and passes the command token on to its neighbour.
// ----------------------------------------------------------------------------
module prt_cell import prt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_step  i_step,
    input  t_bcast i_bc,
    input  logic   i_tok,
    input  logic   i_done,
    output t_cell  o_cell
);

    logic        r_valid, n_valid;
    logic [31:0] r_addr, n_addr;
    logic [15:0] r_port, n_port;
    logic [15:0] r_seq, n_seq;
    logic        r_tok, n_tok;
    logic        r_done, n_done;
    logic        w_act, w_fill, w_clear;

    always_comb begin
        // The done flag means an earlier cell has already taken the command, or the controller refused it at the start.
        w_act   = r_tok && i_step.act && !r_done;
        w_fill  = w_act && (i_bc.op == CMD_REG) && !r_valid;
        w_clear = w_act && (i_bc.op == CMD_UNREG) && r_valid && (r_seq == i_bc.seq_arg);

        n_valid = r_valid;
        n_addr  = r_addr;
        n_port  = r_port;
        n_seq   = r_seq;
        if (w_fill) begin
            n_valid = 1'b1;
            n_addr  = i_bc.addr;
            n_port  = i_bc.port;
            n_seq   = i_bc.issue_seq;
        end else if (w_clear) begin
            n_valid = 1'b0;
        end

        n_tok  = r_tok;
        n_done = r_done;
        if (i_step.shift) begin
            n_tok  = i_tok;
            n_done = i_done;
        end

        o_cell.tok   = r_tok;
        o_cell.done  = r_done || w_fill || w_clear;
        o_cell.valid = r_valid;
        o_cell.seq   = r_seq;
        o_cell.addr  = r_addr;
        o_cell.port  = r_port;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
            r_done  <= n_done;
        end
        r_addr <= n_addr;
        r_port <= n_port;
        r_seq  <= n_seq;
    end

endmodule

// File: rtl/prt_ctl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Peer registration table controller
// Takes a command, walks its token along the cell row, keeps the counters
// and drives the output register.
// ----------------------------------------------------------------------------
module prt_ctl import prt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    prt_req_if.sink           i_req,
    prt_rsp_if.source         o_rsp,
    input  t_cell             i_cells [TABLE_SLOTS],
    output t_step             o_step,
    output t_bcast            o_bc,
    output logic              o_tok0,
    output logic              o_done0
);

    logic             r_busy, n_busy;
    logic             r_tail, n_tail;
    logic             r_tail_done, n_tail_done;
    logic             r_ok, n_ok;
    t_cmd             r_op, n_op;
    logic [31:0]      r_addr, n_addr;
    logic [15:0]      r_port, n_port;
    logic [15:0]      r_seq_arg, n_seq_arg;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_issue_seq, n_issue_seq;

    logic             r_o_valid, n_o_valid;
    t_kind            r_o_kind, n_o_kind;
    logic [15:0]      r_o_seq, n_o_seq;
    logic [31:0]      r_o_addr, n_o_addr;
    logic [15:0]      r_o_port, n_o_port;
    logic             r_o_last, n_o_last;

    logic             w_adv, w_start, w_pre_ok, w_hit, w_done0;
    logic [15:0]      w_e_seq, w_e_port;
    logic [31:0]      w_e_addr;
    logic [TABLE_SLOTS-1:0] w_tok_vec, w_valid_vec;

    // Only the cell holding the token can put its slot on the entry bus.
    always_comb begin
        w_hit    = 1'b0;
        w_e_seq  = '0;
        w_e_addr = '0;
        w_e_port = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            w_tok_vec[i]   = i_cells[i].tok;
            w_valid_vec[i] = i_cells[i].valid;
            if (i_cells[i].tok && i_cells[i].valid) begin
                w_hit    = 1'b1;
                w_e_seq  = w_e_seq | i_cells[i].seq;
                w_e_addr = w_e_addr | i_cells[i].addr;
                w_e_port = w_e_port | i_cells[i].port;
            end
        end
    end

    always_comb begin
        w_adv   = r_busy && (!r_o_valid || o_rsp.ready);
        w_start = i_req.valid && !r_busy;

        w_pre_ok = (i_req.peer_port != 16'd0) && (r_count < CNT_W'(TABLE_SLOTS))
                   && (r_issue_seq < SEQ_MAX);
        case (t_cmd'(i_req.cmd))
            CMD_REG:   w_done0 = !w_pre_ok;
            CMD_UNREG: w_done0 = 1'b0;
            CMD_LIST:  w_done0 = 1'b0;
            default:   w_done0 = 1'b1;
        endcase

        n_busy      = r_busy;
        n_tail      = r_tail;
        n_tail_done = r_tail_done;
        n_ok        = r_ok;
        n_op        = r_op;
        n_addr      = r_addr;
        n_port      = r_port;
        n_seq_arg   = r_seq_arg;
        n_count     = r_count;
        n_issue_seq = r_issue_seq;

        n_o_valid = r_o_valid && !o_rsp.ready;
        n_o_kind  = r_o_kind;
        n_o_seq   = r_o_seq;
        n_o_addr  = r_o_addr;
        n_o_port  = r_o_port;
        n_o_last  = r_o_last;

        if (w_start) begin
            n_busy    = 1'b1;
            n_ok      = w_pre_ok;
            n_op      = t_cmd'(i_req.cmd);
            n_addr    = i_req.peer_addr;
            n_port    = i_req.peer_port;
            n_seq_arg = i_req.seq_arg;
        end

        if (w_adv && !r_tail) begin
            if (i_cells[TABLE_SLOTS-1].tok) begin
                n_tail      = 1'b1;
                n_tail_done = i_cells[TABLE_SLOTS-1].done;
            end
            if ((r_op == CMD_LIST) && w_hit) begin
                n_o_valid = 1'b1;
                n_o_kind  = KIND_ENTRY;
                n_o_seq   = w_e_seq;
                n_o_addr  = w_e_addr;
                n_o_port  = w_e_port;
                n_o_last  = 1'b0;
            end
        end

        // The walk is over: settle the counters and send the closing result.
        if (w_adv && r_tail) begin
            n_busy    = 1'b0;
            n_tail    = 1'b0;
            n_o_valid = 1'b1;
            n_o_kind  = KIND_NOK;
            n_o_seq   = '0;
            n_o_addr  = '0;
            n_o_port  = '0;
            n_o_last  = 1'b1;
            case (r_op)
                CMD_REG: begin
                    if (r_ok && r_tail_done) begin
                        n_o_kind    = KIND_SEQ;
                        n_o_seq     = r_issue_seq;
                        n_count     = r_count + CNT_W'(1);
                        n_issue_seq = r_issue_seq + 16'd1;
                    end
                end
                CMD_UNREG: begin
                    if (r_tail_done) begin
                        n_o_kind = KIND_OK;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
                CMD_LIST: n_o_kind = KIND_END;
                default:  n_o_kind = KIND_NOK;
            endcase
        end

        o_step.shift = w_adv || w_start;
        o_step.act   = w_adv && !r_tail;
        o_bc.op        = r_op;
        o_bc.addr      = r_addr;
        o_bc.port      = r_port;
        o_bc.seq_arg   = r_seq_arg;
        o_bc.issue_seq = r_issue_seq;
        o_tok0         = w_start;
        o_done0        = w_done0;

        i_req.ready    = !r_busy;
        o_rsp.valid    = r_o_valid;
        o_rsp.kind     = r_o_kind;
        o_rsp.seq_out  = r_o_seq;
        o_rsp.addr_out = r_o_addr;
        o_rsp.port_out = r_o_port;
        o_rsp.last     = r_o_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_tail      <= 1'b0;
            r_count     <= '0;
            r_issue_seq <= 16'd1;
            r_o_valid   <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_issue_seq <= n_issue_seq;
            r_o_valid   <= n_o_valid;
        end
        r_tail_done <= n_tail_done;
        r_ok        <= n_ok;
        r_op        <= n_op;
        r_addr      <= n_addr;
        r_port      <= n_port;
        r_seq_arg   <= n_seq_arg;
        r_o_kind    <= n_o_kind;
        r_o_seq     <= n_o_seq;
        r_o_addr    <= n_o_addr;
        r_o_port    <= n_o_port;
        r_o_last    <= n_o_last;
    end

    `ASSERT_HOLDS(a_one_token, i_clk, i_rst_n, $onehot0(w_tok_vec),
                  "more than one token in the row")
    `ASSERT_IMPL(a_idle_no_token, i_clk, i_rst_n, !r_busy || r_tail, w_tok_vec == '0,
                 "token left in the row")
    `ASSERT_IMPL(a_count_match, i_clk, i_rst_n, !r_busy,
                 $countones(w_valid_vec) == int'(r_count), "active count differs from valid slots")
    `ASSERT_HOLDS(a_seq_nonzero, i_clk, i_rst_n, r_issue_seq != 16'd0,
                  "sequence counter wrapped")

endmodule

// File: rtl/peer_registration_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peer registration table
// Keeps up to TABLE_SLOTS registered peers and answers register, unregister
// and list commands.
// ----------------------------------------------------------------------------
// Usage: one command is taken on i_req per transfer, and its results leave on
// o_rsp, one per transfer; the final result of each command carries last.
// Register returns the assigned sequence number or NOK, unregister OK or NOK,
// list one entry per active slot in slot order and then an end marker.
// Each command walks a token through a row of TABLE_SLOTS slot cells, one cell
// per cycle while o_rsp is not stalled, followed by a final step that settles
// the counters and loads the closing result. A new command is taken only once
// that closing result has been loaded into the output register.
// A single output register holds the current result; while the receiver
// stalls, the walk pauses in place, so no result is lost.
// Reset empties every slot and sets the next sequence number to one; no
// clearing pass is needed and a command can be taken straight after reset.
// ----------------------------------------------------------------------------
module peer_registration_table import prt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prt_req_if.sink    i_req,
    prt_rsp_if.source  o_rsp
);

    t_cell  w_cells [TABLE_SLOTS];
    logic   w_tok_in [TABLE_SLOTS];
    logic   w_done_in [TABLE_SLOTS];
    t_step  w_step;
    t_bcast w_bc;
    logic   w_tok0, w_done0;

    prt_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cells (w_cells),
        .o_step  (w_step),
        .o_bc    (w_bc),
        .o_tok0  (w_tok0),
        .o_done0 (w_done0)
    );

    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_tok_in[g]  = w_tok0;
            assign w_done_in[g] = w_done0;
        end else begin : g_body
            assign w_tok_in[g]  = w_cells[g-1].tok;
            assign w_done_in[g] = w_cells[g-1].done;
        end

        prt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (w_step),
            .i_bc    (w_bc),
            .i_tok   (w_tok_in[g]),
            .i_done  (w_done_in[g]),
            .o_cell  (w_cells[g])
        );
    end

endmodule
